FILE: rtl/bpa_pkg.sv
// Shared types, constants and helpers for the buddy page allocator.
// Depends on nothing; bpa_ctrl and buddy_page_allocator import it.
package bpa_pkg;

    localparam int MAX_RANKS = 16;
    localparam int NUM_PAGES = 32768;

    localparam int PAGE_W = $clog2(NUM_PAGES);
    localparam int RANK_W = 5;
    localparam int RIDX_W = $clog2(MAX_RANKS);
    localparam int CNT_W  = 16;
    localparam int HEAD_W = 7;

    // Largest rank whose block still fits in the page pool.
    localparam int POOL_FIT_RANK  = PAGE_W + 1;
    localparam int POOL_MAX_RANK  = (MAX_RANKS < POOL_FIT_RANK) ? MAX_RANKS : POOL_FIT_RANK;

    localparam logic [1:0] MODE_ALLOC  = 2'd0;
    localparam logic [1:0] MODE_FREE   = 2'd1;
    localparam logic [1:0] MODE_QRANK  = 2'd2;
    localparam logic [1:0] MODE_QCOUNT = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_NOSPACE = 2'd2;

    typedef struct packed {
        logic [1:0]        mode;
        logic [RANK_W-1:0] block_rank;
        logic [14:0]       page_index;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [14:0] result_page;
        logic [15:0] result_value;
    } t_rsp;

    typedef struct packed {
        logic              we;
        logic [PAGE_W-1:0] waddr;
        logic [HEAD_W-1:0] wdata;
        logic [PAGE_W-1:0] raddr;
    } t_head_port;

    typedef struct packed {
        logic              we;
        logic [PAGE_W-1:0] waddr;
        logic [PAGE_W-1:0] wdata;
        logic [PAGE_W-1:0] raddr;
    } t_link_port;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_QR_W,
        S_AL_SCAN,
        S_AL_POP,
        S_AL_POPW,
        S_AL_HI,
        S_AL_LO,
        S_FR_W,
        S_FR_CHK,
        S_FR_BW,
        S_UL_POPW,
        S_UL_WALK,
        S_UL_WW,
        S_UL_FIXW,
        S_FR_MERGE,
        S_FR_PUSH,
        S_DONE
    } t_state;

    // Head entry: bit 6 head, bit 5 free, bits 4..0 rank.
    function automatic logic [HEAD_W-1:0] make_head(input logic is_free,
                                                    input logic [RANK_W-1:0] rk);
        make_head = {1'b1, is_free, rk};
    endfunction

    // Clamp a written pool rank into the legal range.
    function automatic logic [RANK_W-1:0] clamp_rank(input logic [RANK_W-1:0] pr);
        logic [RANK_W-1:0] r;
        r = pr;
        if (r == '0) begin
            r = RANK_W'(1);
        end
        if (r > RANK_W'(POOL_MAX_RANK)) begin
            r = RANK_W'(POOL_MAX_RANK);
        end
        clamp_rank = r;
    endfunction

endpackage

FILE: rtl/bpa_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read output.
// Depends on nothing.
module bpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

FILE: rtl/bpa_ctrl.sv
// Sequencer of the buddy allocator: free lists, counts and all memory accesses.
// Depends on bpa_pkg; drives the head table and link RAMs in the top level.
module bpa_ctrl (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_init,
    input  logic [bpa_pkg::RANK_W-1:0] i_init_rank,
    input  logic                       i_req_valid,
    output logic                       o_req_ready,
    input  bpa_pkg::t_req              i_req,
    output logic                       o_res_valid,
    input  logic                       i_res_ready,
    output bpa_pkg::t_rsp              o_res,
    output bpa_pkg::t_head_port        o_head,
    input  logic [bpa_pkg::HEAD_W-1:0] i_head_rdata,
    output bpa_pkg::t_link_port        o_link,
    input  logic [bpa_pkg::PAGE_W-1:0] i_link_rdata
);
    import bpa_pkg::*;

    t_state            r_state, n_state;
    logic [1:0]        r_mode, n_mode;
    logic [RANK_W-1:0] r_rank, n_rank;
    logic [PAGE_W-1:0] r_page, n_page;
    logic [RANK_W-1:0] r_rk, n_rk;
    logic [PAGE_W-1:0] r_pg, n_pg;
    logic [PAGE_W-1:0] r_bud, n_bud;
    logic [PAGE_W-1:0] r_cur, n_cur;
    logic [CNT_W-1:0]  r_iter, n_iter;
    logic [1:0]        r_status, n_status;
    logic [PAGE_W-1:0] r_rpage, n_rpage;
    logic [15:0]       r_rval, n_rval;
    logic [PAGE_W-1:0] r_clr_addr, n_clr_addr;
    logic [RANK_W-1:0] r_eff, n_eff;
    logic [PAGE_W-1:0] r_list_head [MAX_RANKS];
    logic [PAGE_W-1:0] n_list_head [MAX_RANKS];
    logic [CNT_W-1:0]  r_free_cnt  [MAX_RANKS];
    logic [CNT_W-1:0]  n_free_cnt  [MAX_RANKS];

    logic [RANK_W-1:0] w_rkm1;
    logic [RIDX_W-1:0] w_ridx;
    logic [PAGE_W-1:0] w_half;
    logic [PAGE_W-1:0] w_upper;
    logic [RANK_W-1:0] w_rank_m1;
    logic [RIDX_W-1:0] w_req_ridx;
    logic              w_req_rank_ok;
    logic              w_accept;
    logic [RANK_W-1:0] w_init_m1;

    assign w_rkm1        = r_rk - RANK_W'(1);
    assign w_ridx        = w_rkm1[RIDX_W-1:0];
    assign w_half        = PAGE_W'(1) << w_rkm1;
    assign w_upper       = r_pg + w_half;
    assign w_rank_m1     = i_req.block_rank - RANK_W'(1);
    assign w_req_ridx    = w_rank_m1[RIDX_W-1:0];
    assign w_req_rank_ok = (i_req.block_rank != '0) &&
                           (i_req.block_rank <= RANK_W'(MAX_RANKS));
    assign w_accept      = i_req_valid && o_req_ready;
    assign w_init_m1     = i_init_rank - RANK_W'(1);

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_clr_addr == '1) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_req_valid) begin
                    case (i_req.mode)
                        MODE_ALLOC:  n_state = w_req_rank_ok ? S_AL_SCAN : S_DONE;
                        MODE_FREE:   n_state = S_FR_W;
                        MODE_QRANK:  n_state = S_QR_W;
                        default:     n_state = S_DONE;
                    endcase
                end
            end
            S_QR_W:    n_state = S_DONE;
            S_AL_SCAN: begin
                if (r_free_cnt[w_ridx] != '0) n_state = S_AL_POP;
                else if (r_rk == RANK_W'(MAX_RANKS)) n_state = S_DONE;
            end
            S_AL_POP:  n_state = S_AL_POPW;
            S_AL_POPW: n_state = (r_rk > r_rank) ? S_AL_HI : S_DONE;
            S_AL_HI:   n_state = S_AL_LO;
            S_AL_LO:   n_state = S_AL_POP;
            S_FR_W: begin
                if (!i_head_rdata[6] || i_head_rdata[5]) n_state = S_DONE;
                else n_state = S_FR_CHK;
            end
            S_FR_CHK:  n_state = (r_rk < r_eff) ? S_FR_BW : S_FR_PUSH;
            S_FR_BW: begin
                if (i_head_rdata != make_head(1'b1, r_rk)) n_state = S_FR_PUSH;
                else if (r_free_cnt[w_ridx] == '0) n_state = S_FR_MERGE;
                else if (r_list_head[w_ridx] == r_bud) n_state = S_UL_POPW;
                else n_state = S_UL_WALK;
            end
            S_UL_POPW: n_state = S_FR_MERGE;
            S_UL_WALK: n_state = (r_iter < r_free_cnt[w_ridx]) ? S_UL_WW : S_FR_MERGE;
            S_UL_WW:   n_state = (i_link_rdata == r_bud) ? S_UL_FIXW : S_UL_WALK;
            S_UL_FIXW: n_state = S_FR_MERGE;
            S_FR_MERGE: n_state = S_FR_CHK;
            S_FR_PUSH: n_state = S_DONE;
            S_DONE: begin
                if (i_res_ready) n_state = S_IDLE;
            end
            default:   n_state = S_IDLE;
        endcase
        if (i_init) n_state = S_CLEAR;
    end

    // Handshake and memory port outputs.
    always_comb begin
        o_req_ready = (r_state == S_IDLE);
        o_res_valid = (r_state == S_DONE);
        o_res       = '{status: r_status, result_page: r_rpage, result_value: r_rval};
        o_head      = '{we: 1'b0, waddr: r_pg, wdata: '0, raddr: r_page};
        o_link      = '{we: 1'b0, waddr: r_pg, wdata: r_list_head[w_ridx], raddr: r_pg};
        case (r_state)
            S_CLEAR: begin
                o_head.we    = 1'b1;
                o_head.waddr = r_clr_addr;
                o_head.wdata = (r_clr_addr == '0) ? make_head(1'b1, r_eff) : '0;
            end
            S_IDLE: begin
                o_head.raddr = i_req.page_index;
            end
            S_AL_POP: begin
                o_link.raddr = r_list_head[w_ridx];
            end
            S_AL_POPW: begin
                if (r_rk <= r_rank) begin
                    o_head.we    = 1'b1;
                    o_head.waddr = r_pg;
                    o_head.wdata = make_head(1'b0, r_rk);
                end
            end
            S_AL_HI: begin
                o_link.we    = 1'b1;
                o_link.waddr = w_upper;
                o_head.we    = 1'b1;
                o_head.waddr = w_upper;
                o_head.wdata = make_head(1'b1, r_rk);
            end
            S_AL_LO, S_FR_PUSH: begin
                o_link.we    = 1'b1;
                o_head.we    = 1'b1;
                o_head.wdata = make_head(1'b1, r_rk);
            end
            S_FR_W: begin
                if (i_head_rdata[6] && !i_head_rdata[5]) begin
                    o_head.we    = 1'b1;
                    o_head.waddr = r_page;
                end
            end
            S_FR_CHK: begin
                o_head.raddr = r_pg ^ w_half;
            end
            S_FR_BW: begin
                o_link.raddr = r_bud;
            end
            S_UL_WALK: begin
                o_link.raddr = r_cur;
            end
            S_UL_WW: begin
                o_link.raddr = r_bud;
            end
            S_UL_FIXW: begin
                o_link.we    = 1'b1;
                o_link.waddr = r_cur;
                o_link.wdata = i_link_rdata;
            end
            S_FR_MERGE: begin
                o_head.we    = 1'b1;
                o_head.waddr = r_bud;
            end
            default: begin
                o_head.we = 1'b0;
            end
        endcase
    end

    // Datapath next values.
    always_comb begin
        n_mode      = r_mode;
        n_rank      = r_rank;
        n_page      = r_page;
        n_rk        = r_rk;
        n_pg        = r_pg;
        n_bud       = r_bud;
        n_cur       = r_cur;
        n_iter      = r_iter;
        n_status    = r_status;
        n_rpage     = r_rpage;
        n_rval      = r_rval;
        n_clr_addr  = r_clr_addr;
        n_eff       = r_eff;
        n_list_head = r_list_head;
        n_free_cnt  = r_free_cnt;
        case (r_state)
            S_CLEAR: n_clr_addr = r_clr_addr + PAGE_W'(1);
            S_IDLE: begin
                if (w_accept) begin
                    n_mode   = i_req.mode;
                    n_rank   = i_req.block_rank;
                    n_page   = i_req.page_index;
                    n_rk     = i_req.block_rank;
                    n_status = ST_OK;
                    n_rpage  = '0;
                    n_rval   = '0;
                    if ((i_req.mode == MODE_ALLOC || i_req.mode == MODE_QCOUNT) &&
                        !w_req_rank_ok) begin
                        n_status = ST_INVALID;
                    end else if (i_req.mode == MODE_QCOUNT) begin
                        n_rval = r_free_cnt[w_req_ridx];
                    end
                end
            end
            S_QR_W: begin
                if (!i_head_rdata[6]) n_status = ST_INVALID;
                else n_rval = 16'(i_head_rdata[RANK_W-1:0]);
            end
            S_AL_SCAN: begin
                if (r_free_cnt[w_ridx] == '0) begin
                    if (r_rk == RANK_W'(MAX_RANKS)) n_status = ST_NOSPACE;
                    else n_rk = r_rk + RANK_W'(1);
                end
            end
            S_AL_POP: n_pg = r_list_head[w_ridx];
            S_AL_POPW: begin
                n_list_head[w_ridx] = i_link_rdata;
                n_free_cnt[w_ridx]  = r_free_cnt[w_ridx] - CNT_W'(1);
                if (r_rk > r_rank) n_rk = r_rk - RANK_W'(1);
                else n_rpage = r_pg;
            end
            S_AL_HI: begin
                n_list_head[w_ridx] = w_upper;
                n_free_cnt[w_ridx]  = r_free_cnt[w_ridx] + CNT_W'(1);
            end
            S_AL_LO, S_FR_PUSH: begin
                n_list_head[w_ridx] = r_pg;
                n_free_cnt[w_ridx]  = r_free_cnt[w_ridx] + CNT_W'(1);
            end
            S_FR_W: begin
                if (!i_head_rdata[6] || i_head_rdata[5]) begin
                    n_status = ST_INVALID;
                end else begin
                    n_rk = i_head_rdata[RANK_W-1:0];
                    n_pg = r_page;
                end
            end
            S_FR_CHK: n_bud = r_pg ^ w_half;
            S_FR_BW: begin
                n_cur  = r_list_head[w_ridx];
                n_iter = CNT_W'(1);
            end
            S_UL_POPW: begin
                n_list_head[w_ridx] = i_link_rdata;
                n_free_cnt[w_ridx]  = r_free_cnt[w_ridx] - CNT_W'(1);
            end
            S_UL_WW: begin
                if (i_link_rdata != r_bud) begin
                    n_cur  = i_link_rdata;
                    n_iter = r_iter + CNT_W'(1);
                end
            end
            S_UL_FIXW: n_free_cnt[w_ridx] = r_free_cnt[w_ridx] - CNT_W'(1);
            S_FR_MERGE: begin
                n_pg = r_pg & ~w_half;
                n_rk = r_rk + RANK_W'(1);
            end
            default: n_iter = r_iter;
        endcase
        // Reinitialize the pool as one free block at page zero.
        if (i_init) begin
            n_clr_addr = '0;
            n_eff      = i_init_rank;
            for (int i = 0; i < MAX_RANKS; i++) begin
                n_list_head[i] = '0;
                n_free_cnt[i]  = '0;
            end
            n_free_cnt[w_init_m1[RIDX_W-1:0]] = CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_addr <= '0;
            r_eff      <= RANK_W'(POOL_MAX_RANK);
            for (int i = 0; i < MAX_RANKS; i++) begin
                r_list_head[i] <= '0;
                r_free_cnt[i]  <= (i == POOL_MAX_RANK - 1) ? CNT_W'(1) : '0;
            end
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_eff       <= n_eff;
            r_list_head <= n_list_head;
            r_free_cnt  <= n_free_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode   <= n_mode;
        r_rank   <= n_rank;
        r_page   <= n_page;
        r_rk     <= n_rk;
        r_pg     <= n_pg;
        r_bud    <= n_bud;
        r_cur    <= n_cur;
        r_iter   <= n_iter;
        r_status <= n_status;
        r_rpage  <= n_rpage;
        r_rval   <= n_rval;
    end

    logic [PAGE_W-1:0] w_align_mask;
    assign w_align_mask = (PAGE_W'(1) << (r_rank - RANK_W'(1))) - PAGE_W'(1);

    a_alloc_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_mode == MODE_ALLOC && r_status == ST_OK)
        |-> ((r_rpage & w_align_mask) == '0))
        else $error("allocated page not aligned to its rank");

    a_nospace_alloc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_status == ST_NOSPACE) |-> (r_mode == MODE_ALLOC))
        else $error("no-space status outside allocation");

    a_clear_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR && n_state == S_IDLE) |-> (r_clr_addr == '1))
        else $error("clearing pass left early");

    a_walk_iter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UL_WW) |=> (r_state != S_UL_WALK || r_iter != '0))
        else $error("list walk index wrapped");
endmodule

FILE: rtl/buddy_page_allocator.sv
// Top level of the buddy page allocator: head table and link RAMs, response register.
// Depends on bpa_pkg, bpa_ram and bpa_ctrl.
//
//  Channel   Dir  Handshake                  Payload
//  request   in   i_req_valid / o_req_ready  i_req  (t_req: mode, block_rank, page_index)
//  response  out  o_rsp_valid / i_rsp_ready  o_rsp  (t_rsp: status, result_page, result_value)
//  config    in   i_cfg_valid / o_cfg_ready  i_cfg_data (pool_rank, 5 bits)
//
// A count query is answered from the free counts, a rank query from the head table. An alloc
// scans ranks upward from the requested one up to rank 16, pops a block and splits it once
// per level down. A free checks the page's head entry, then per merge level reads the buddy's
// head and unlinks the buddy at its list head or by walking the list and patching the link;
// the link RAM's single read port sets that walk. Reset and every config write start a
// clearing pass over the 32768 head entries, one a cycle, while no request is accepted.
// The response register holds a finished result while the next request enters.
module buddy_page_allocator (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_req_valid,
    output logic                       o_req_ready,
    input  bpa_pkg::t_req              i_req,
    output logic                       o_rsp_valid,
    input  logic                       i_rsp_ready,
    output bpa_pkg::t_rsp              o_rsp,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [bpa_pkg::RANK_W-1:0] i_cfg_data
);
    import bpa_pkg::*;

    t_head_port        w_head;
    t_link_port        w_link;
    logic [HEAD_W-1:0] w_head_rdata;
    logic [PAGE_W-1:0] w_link_rdata;
    logic              w_res_valid;
    logic              w_res_ready;
    t_rsp              w_res;
    logic              w_init;

    logic              r_rsp_valid, n_rsp_valid;
    t_rsp              r_rsp, n_rsp;

    // Config is always taken; a write restarts the pool.
    assign o_cfg_ready = 1'b1;
    assign w_init      = i_cfg_valid;

    bpa_ram #(.WIDTH(HEAD_W), .DEPTH(NUM_PAGES)) u_head_ram (
        .i_clk   (i_clk),
        .i_we    (w_head.we),
        .i_waddr (w_head.waddr),
        .i_wdata (w_head.wdata),
        .i_raddr (w_head.raddr),
        .o_rdata (w_head_rdata)
    );

    bpa_ram #(.WIDTH(PAGE_W), .DEPTH(NUM_PAGES)) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (w_link.we),
        .i_waddr (w_link.waddr),
        .i_wdata (w_link.wdata),
        .i_raddr (w_link.raddr),
        .o_rdata (w_link_rdata)
    );

    bpa_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_init       (w_init),
        .i_init_rank  (clamp_rank(i_cfg_data)),
        .i_req_valid  (i_req_valid),
        .o_req_ready  (o_req_ready),
        .i_req        (i_req),
        .o_res_valid  (w_res_valid),
        .i_res_ready  (w_res_ready),
        .o_res        (w_res),
        .o_head       (w_head),
        .i_head_rdata (w_head_rdata),
        .o_link       (w_link),
        .i_link_rdata (w_link_rdata)
    );

    // Response slot: take a new result when empty or draining this cycle.
    assign w_res_ready = !r_rsp_valid || i_rsp_ready;

    always_comb begin
        n_rsp_valid = r_rsp_valid;
        n_rsp       = r_rsp;
        if (w_res_ready) begin
            n_rsp_valid = w_res_valid;
            if (w_res_valid) n_rsp = w_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rsp_valid <= 1'b0;
        end else begin
            r_rsp_valid <= n_rsp_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rsp <= n_rsp;
    end

    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;
endmodule
